// ----- hw/rtl/crpc_pkg.sv -----
// Shared constants, types and index helpers for the pickup route cost block.
`default_nettype none

package crpc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W = 16;
    localparam int WGT_IN_W = 16;
    localparam int DIST_W  = 17;
    localparam int PATH_W  = 32;
    localparam int WGT_W   = 32;
    localparam int VAL_W   = 49;
    localparam int COST_W  = 48;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // one deque entry: split value and weight total before that point
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [WGT_W-1:0]        weight;
    } cand_t;

    function automatic idx_t idx_prev(input idx_t i);
        idx_t r;
        if (i == '0)
            r = idx_t'(MAX_POINTS - 1);
        else
            r = i - idx_t'(1);
        return r;
    endfunction

    function automatic idx_t idx_next(input idx_t i);
        idx_t r;
        if (i == idx_t'(MAX_POINTS - 1))
            r = '0;
        else
            r = i + idx_t'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crpc_mem.sv -----
// Candidate deque storage: one write port, one registered read port.
`default_nettype none

module crpc_mem (
    input  wire logic           clk,
    input  wire logic           wr_en,
    input  wire crpc_pkg::idx_t  wr_addr,
    input  wire crpc_pkg::cand_t wr_data,
    input  wire logic           rd_en,
    input  wire crpc_pkg::idx_t  rd_addr,
    output crpc_pkg::cand_t      rd_data
);

    crpc_pkg::cand_t ram_reg [crpc_pkg::MAX_POINTS];
    crpc_pkg::cand_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ram_reg[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/crpc_dist.sv -----
// Manhattan distances: point to origin and point to previous point.
`default_nettype none

module crpc_dist (
    input  wire logic signed [crpc_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [crpc_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [crpc_pkg::COORD_W-1:0] last_x,
    input  wire logic signed [crpc_pkg::COORD_W-1:0] last_y,
    output logic [crpc_pkg::DIST_W-1:0]              home_dist,
    output logic [crpc_pkg::DIST_W-1:0]              leg
);

    logic signed [crpc_pkg::COORD_W:0] ex, ey, dx, dy;
    logic signed [crpc_pkg::COORD_W:0] ax, ay, adx, ady;

    always_comb
    begin
        ex  = {point_x[crpc_pkg::COORD_W-1], point_x};
        ey  = {point_y[crpc_pkg::COORD_W-1], point_y};
        dx  = ex - {last_x[crpc_pkg::COORD_W-1], last_x};
        dy  = ey - {last_y[crpc_pkg::COORD_W-1], last_y};
        ax  = ex[crpc_pkg::COORD_W] ? -ex : ex;
        ay  = ey[crpc_pkg::COORD_W] ? -ey : ey;
        adx = dx[crpc_pkg::COORD_W] ? -dx : dx;
        ady = dy[crpc_pkg::COORD_W] ? -dy : dy;
        // magnitudes fit in COORD_W unsigned bits
        home_dist = {1'b0, ax[crpc_pkg::COORD_W-1:0]} + {1'b0, ay[crpc_pkg::COORD_W-1:0]};
        leg       = {1'b0, adx[crpc_pkg::COORD_W-1:0]} + {1'b0, ady[crpc_pkg::COORD_W-1:0]};
    end

endmodule

`default_nettype wire

// ----- hw/rtl/capacitated_pickup_route_cost.sv -----
// Top level: sequencer over the candidate deque memory for the route cost DP.
// Each item is prepared, pushed, checked for expiry at the tail and for eviction at the head,
// then the result is read and loaded; each deque step is one memory read and one compare.
// Overweight items (every candidate expired) leave from the expiry check with cost zero.
// One item in work; the next is taken only once the result is loaded (held while full).
// Reset clears control state and sets capacity to 65535; candidate memory is not cleared.
`default_nettype none

module capacitated_pickup_route_cost (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // capacity
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,       // point_x, point_y, point_weight
    input  wire logic        s_tuser,       // first_point
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,       // best_cost
    output logic             m_tuser        // overweight
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PREP    = 4'd1;
    localparam logic [3:0] S_PUSH    = 4'd2;
    localparam logic [3:0] S_EXP_RD  = 4'd3;
    localparam logic [3:0] S_EXP_CHK = 4'd4;
    localparam logic [3:0] S_EV_RD   = 4'd5;
    localparam logic [3:0] S_EV_CHK  = 4'd6;
    localparam logic [3:0] S_FIN_RD  = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;
    localparam logic [3:0] S_OW      = 4'd9;

    localparam int CW = crpc_pkg::COORD_W;

    logic [3:0] state_reg, state_next;
    logic [15:0] capacity_reg;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [crpc_pkg::WGT_IN_W-1:0] w_reg, w_next;
    logic first_reg, first_next;

    logic signed [CW-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [crpc_pkg::PATH_W-1:0] path_reg, path_next;
    logic [crpc_pkg::WGT_W-1:0] wt_reg, wt_next, pw_reg, pw_next;
    logic [crpc_pkg::COST_W-1:0] last_cost_reg, last_cost_next;
    logic [crpc_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [crpc_pkg::PATH_W:0] pd_reg, pd_next;
    logic signed [crpc_pkg::VAL_W-1:0] cand_reg, cand_next;
    crpc_pkg::idx_t head_reg, head_next, tail_reg, tail_next;
    crpc_pkg::cnt_t count_reg, count_next;

    logic m_valid_reg, m_valid_next;
    logic [crpc_pkg::COST_W-1:0] m_cost_reg, m_cost_next;
    logic m_ow_reg, m_ow_next;

    logic [crpc_pkg::DIST_W-1:0] dist_c, leg_c;

    logic mem_wr_en, mem_rd_en;
    crpc_pkg::idx_t mem_wr_addr, mem_rd_addr;
    crpc_pkg::cand_t mem_wr_data, mem_rd_data;

    logic signed [crpc_pkg::VAL_W-1:0] cand_c;
    crpc_pkg::idx_t head_p, tail_p, second_c;
    crpc_pkg::cnt_t count_p;
    logic [crpc_pkg::WGT_W-1:0] trip_c;
    logic [crpc_pkg::COST_W-1:0] cost_c;
    logic out_free;

    crpc_dist u_dist (
        .point_x   (x_reg),
        .point_y   (y_reg),
        .last_x    (last_x_reg),
        .last_y    (last_y_reg),
        .home_dist (dist_c),
        .leg       (leg_c)
    );

    crpc_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_cost_reg;
    assign m_tuser  = m_ow_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        // push bookkeeping: drop oldest if full, then take the slot before head
        cand_c = crpc_pkg::VAL_W'(last_cost_reg) - crpc_pkg::VAL_W'(path_reg)
                 + crpc_pkg::VAL_W'(dist_reg);
        tail_p  = tail_reg;
        count_p = count_reg;
        if (count_reg >= crpc_pkg::cnt_t'(crpc_pkg::MAX_POINTS))
        begin
            tail_p  = crpc_pkg::idx_prev(tail_reg);
            count_p = count_reg - crpc_pkg::cnt_t'(1);
        end
        if (count_p == '0)
        begin
            head_p = '0;
            tail_p = '0;
        end
        else
        begin
            head_p = crpc_pkg::idx_prev(head_reg);
        end
        second_c = crpc_pkg::idx_next(head_reg);
        trip_c   = wt_reg - mem_rd_data.weight;
        cost_c   = crpc_pkg::COST_W'(mem_rd_data.value) + crpc_pkg::COST_W'(pd_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        first_next     = first_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        path_next      = path_reg;
        wt_next        = wt_reg;
        pw_next        = pw_reg;
        last_cost_next = last_cost_reg;
        dist_next      = dist_reg;
        pd_next        = pd_reg;
        cand_next      = cand_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_cost_next    = m_cost_reg;
        m_ow_next      = m_ow_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = head_p;
        mem_wr_data    = '{value: cand_c, weight: pw_reg};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = tail_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = s_tdata[CW-1:0];
                    y_next     = s_tdata[2*CW-1:CW];
                    w_next     = s_tdata[2*CW+crpc_pkg::WGT_IN_W-1:2*CW];
                    first_next = s_tuser;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                dist_next   = dist_c;
                last_x_next = x_reg;
                last_y_next = y_reg;
                if (first_reg)
                begin
                    path_next      = '0;
                    pw_next        = '0;
                    wt_next        = crpc_pkg::WGT_W'(w_reg);
                    last_cost_next = '0;
                    head_next      = '0;
                    tail_next      = '0;
                    count_next     = '0;
                end
                else
                begin
                    path_next = path_reg + crpc_pkg::PATH_W'(leg_c);
                    pw_next   = wt_reg;
                    wt_next   = wt_reg + crpc_pkg::WGT_W'(w_reg);
                end
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                mem_wr_en  = 1'b1;
                cand_next  = cand_c;
                head_next  = head_p;
                tail_next  = tail_p;
                count_next = count_p + crpc_pkg::cnt_t'(1);
                pd_next    = {1'b0, path_reg} + (crpc_pkg::PATH_W+1)'(dist_reg);
                state_next = S_EXP_RD;
            end
            S_EXP_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_EXP_CHK;
            end
            S_EXP_CHK:
            begin
                if (trip_c > crpc_pkg::WGT_W'(capacity_reg))
                begin
                    count_next = count_reg - crpc_pkg::cnt_t'(1);
                    if (count_reg == crpc_pkg::cnt_t'(1))
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        state_next = S_OW;
                    end
                    else
                    begin
                        tail_next  = crpc_pkg::idx_prev(tail_reg);
                        state_next = S_EXP_RD;
                    end
                end
                else
                begin
                    state_next = S_EV_RD;
                end
            end
            S_EV_RD:
            begin
                if (count_reg > crpc_pkg::cnt_t'(1))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = second_c;
                    state_next  = S_EV_CHK;
                end
                else
                begin
                    state_next = S_FIN_RD;
                end
            end
            S_EV_CHK:
            begin
                // the head always holds the new candidate; shift it over a no-better one
                if ($signed(cand_reg) > $signed(mem_rd_data.value))
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = second_c;
                    mem_wr_data = '{value: cand_reg, weight: pw_reg};
                    head_next   = second_c;
                    count_next  = count_reg - crpc_pkg::cnt_t'(1);
                    state_next  = S_EV_RD;
                end
            end
            S_FIN_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    m_cost_next    = cost_c;
                    m_ow_next      = 1'b0;
                    last_cost_next = cost_c;
                    state_next     = S_IDLE;
                end
            end
            S_OW:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_cost_next  = '0;
                    m_ow_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= 16'hFFFF;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            path_reg      <= '0;
            wt_reg        <= '0;
            last_cost_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            path_reg      <= path_next;
            wt_reg        <= wt_next;
            last_cost_reg <= last_cost_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        w_reg      <= w_next;
        first_reg  <= first_next;
        pw_reg     <= pw_next;
        dist_reg   <= dist_next;
        pd_reg     <= pd_next;
        cand_reg   <= cand_next;
        m_cost_reg <= m_cost_next;
        m_ow_reg   <= m_ow_next;
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for the capacitated pickup route cost block.
`timescale 1ns / 100ps

module testbench;

    localparam int          DEQ_DEPTH   = crpc_pkg::MAX_POINTS;
    localparam int          COST_W      = crpc_pkg::COST_W;
    localparam int          PATH_W      = crpc_pkg::PATH_W;
    localparam int          WGT_W       = crpc_pkg::WGT_W;
    localparam int          VAL_W       = crpc_pkg::VAL_W;
    localparam logic [15:0] CAP_MAX     = 16'hFFFF;
    localparam int          STALL_LIMIT = 20000;
    localparam int          SETTLE      = 12;
    localparam int          N_PROBES    = 22;
    localparam int          FILL_LEN    = DEQ_DEPTH + 6;

    typedef enum int {SCATTER, OUTWARD, FULL_RANGE, WALK} case_shape_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              ovw;
    } route_res_t;

    typedef struct {
        int                item;
        logic [COST_W-1:0] cost;
        logic              ovw;
    } owed_t;

    // pinned rows carry a hand-worked result instead of the predicted one
    typedef struct {
        logic [15:0]        cap;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic               first;
        logic               pinned;
        logic [COST_W-1:0]  cost;
        logic               ovw;
    } probe_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;       // point_x, point_y, point_weight
    logic        s_tuser;       // first_point
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;       // best_cost
    logic        m_tuser;       // overweight

    capacitated_pickup_route_cost uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // route state mirror
    logic [15:0]             cap_now;
    int                      last_x;
    int                      last_y;
    logic [PATH_W-1:0]       path_len;
    logic [WGT_W-1:0]        wt_total;
    logic [COST_W-1:0]       last_cost;
    logic signed [VAL_W-1:0] split_val [DEQ_DEPTH];
    logic [WGT_W-1:0]        split_wt  [DEQ_DEPTH];
    int                      q_head;
    int                      q_tail;
    int                      q_count;

    owed_t  owed_costs[$];
    owed_t  due;
    probe_t probe_tab [N_PROBES];

    logic idle_on;
    int   n_points;
    int   n_results;
    int   n_ovw;
    int   n_cases;
    int   n_cap_writes;
    int   n_drops;
    int   deepest;
    int   n_errors;
    int   quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int prev_slot(input int i);
        return (i == 0) ? DEQ_DEPTH - 1 : i - 1;
    endfunction

    function automatic void clear_route();
        last_x    = 0;
        last_y    = 0;
        path_len  = '0;
        wt_total  = '0;
        last_cost = '0;
        q_head    = 0;
        q_tail    = 0;
        q_count   = 0;
    endfunction

    // one point through the split-cost deque; returns the least route cost so far
    function automatic route_res_t route_step(input logic signed [15:0] px,
                                              input logic signed [15:0] py,
                                              input logic [15:0] pw, input logic pf);
        int                      xi;
        int                      yi;
        int                      home_dist;
        int                      second;
        logic [WGT_W-1:0]        prev_wt;
        logic [WGT_W-1:0]        trip;
        logic [63:0]             sum;
        logic signed [VAL_W-1:0] cand;
        route_res_t              r;
        xi = px;
        yi = py;
        if (pf)
            clear_route();
        home_dist = mag(xi) + mag(yi);
        if (!pf)
            path_len = path_len + PATH_W'(mag(xi - last_x) + mag(yi - last_y));
        last_x = xi;
        last_y = yi;
        prev_wt  = wt_total;
        wt_total = wt_total + WGT_W'(pw);
        sum  = 64'(last_cost) - 64'(path_len) + 64'(home_dist);
        cand = sum[VAL_W-1:0];

        if (q_count >= DEQ_DEPTH)
        begin
            q_tail = prev_slot(q_tail);
            q_count--;
            n_drops++;
        end
        if (q_count == 0)
        begin
            q_head = 0;
            q_tail = 0;
        end
        else
            q_head = prev_slot(q_head);
        split_val[q_head] = cand;
        split_wt[q_head]  = prev_wt;
        q_count++;
        if (q_count > deepest)
            deepest = q_count;

        // too-heavy trips leave from the old end
        while (q_count > 0)
        begin
            trip = wt_total - split_wt[q_tail];
            if (trip <= WGT_W'(cap_now))
                break;
            q_count--;
            if (q_count == 0)
            begin
                q_head = 0;
                q_tail = 0;
            end
            else
                q_tail = prev_slot(q_tail);
        end
        if (q_count == 0)
        begin
            r.cost = '0;
            r.ovw  = 1'b1;
            return r;
        end

        // newest absorbs any neighbour that is no better
        while (q_count > 1)
        begin
            second = (q_head == DEQ_DEPTH - 1) ? 0 : q_head + 1;
            if (split_val[q_head] > split_val[second])
                break;
            split_val[second] = split_val[q_head];
            split_wt[second]  = split_wt[q_head];
            q_head = second;
            q_count--;
        end

        last_cost = COST_W'(split_val[q_tail]) + COST_W'(path_len) + COST_W'(home_dist);
        r.cost = last_cost;
        r.ovw  = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int item,
                                   input logic [47:0] got, input logic [47:0] want);
        $display("ERROR item %0d %s: got %0d, want %0d", item, what, got, want);
        n_errors++;
    endtask

    task automatic push_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic [15:0] pw, input logic pf, input logic pinned,
                              input logic [COST_W-1:0] pin_cost, input logic pin_ovw);
        route_res_t r;
        owed_t      o;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {pw, py, px};
        s_tuser  = pf;
        do
            @(posedge clk);
        while (!s_tready);
        r = route_step(px, py, pw, pf);
        o.item = n_points;
        o.cost = pinned ? pin_cost : r.cost;
        o.ovw  = pinned ? pin_ovw : r.ovw;
        owed_costs.push_back(o);
        n_points++;
        if (pf)
            n_cases++;
    endtask

    // hold the sender until every owed result is back
    task automatic settle_all();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (owed_costs.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] v);
        settle_all();
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        cap_now     = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        n_cap_writes++;
    endtask

    // random cases: mostly well-formed runs of points, some broken by stray first marks
    task automatic run_phase(input logic [15:0] cap, input int n_items, input logic idling);
        int          left;
        int          len;
        int          c;
        int          wv;
        int          x;
        int          y;
        logic        pf;
        logic [15:0] pw;
        case_shape_t shape;
        set_capacity(cap);
        idle_on = idling;
        left = n_items;
        c = cap;
        while (left > 0)
        begin
            len = $urandom_range(1, 24);
            if (len > left)
                len = left;
            shape = case_shape_t'($urandom_range(0, 3));
            x = int'($urandom_range(0, 6)) - 3;
            y = int'($urandom_range(0, 6)) - 3;
            if (shape == OUTWARD)
            begin
                x = $urandom_range(0, 3);
                y = $urandom_range(0, 3);
            end
            for (int i = 0; i < len; i++)
            begin
                if (i == 0)
                    pf = ($urandom_range(0, 9) != 0);
                else
                    pf = ($urandom_range(0, 49) == 0);
                case (shape)
                    SCATTER:
                    begin
                        x = int'($urandom_range(0, 100)) - 50;
                        y = int'($urandom_range(0, 100)) - 50;
                    end
                    OUTWARD:
                    begin
                        x = x + int'($urandom_range(0, 4));
                        y = y + int'($urandom_range(0, 4));
                    end
                    FULL_RANGE:
                    begin
                        x = int'(16'($urandom));
                        y = int'(16'($urandom));
                    end
                    default:
                    begin
                        x = x + int'($urandom_range(0, 40)) - 20;
                        y = y + int'($urandom_range(0, 40)) - 20;
                    end
                endcase
                case ($urandom_range(0, 7))
                    0: pw = 16'($urandom);
                    1:
                    begin
                        wv = c + int'($urandom_range(0, 4)) - 2;
                        if (wv < 0)
                            wv = 0;
                        if (wv > 65535)
                            wv = 65535;
                        pw = 16'(wv);
                    end
                    default: pw = 16'($urandom_range(0, c / 4));
                endcase
                push_point(16'(x), 16'(y), pw, pf, 1'b0, '0, 1'b0);
            end
            left = left - len;
            if ($urandom_range(0, 29) == 0)
                settle_all();
        end
    endtask

    // receiver side stalls
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (m_tuser === 1'b1)
                n_ovw++;
            if (owed_costs.size() == 0)
                report_mismatch("result with nothing owed", n_results, m_tdata, '0);
            else
            begin
                due = owed_costs.pop_front();
                if (m_tdata !== due.cost)
                    report_mismatch("best_cost", due.item, m_tdata, due.cost);
                if (m_tuser !== due.ovw)
                    report_mismatch("overweight", due.item, 48'(m_tuser), 48'(due.ovw));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results owed",
                         quiet_cycles, owed_costs.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int fx;
        int fy;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        idle_on      = 1'b1;
        n_points     = 0;
        n_results    = 0;
        n_ovw        = 0;
        n_cases      = 0;
        n_cap_writes = 0;
        n_drops      = 0;
        deepest      = 0;
        n_errors     = 0;
        quiet_cycles = 0;
        cap_now      = CAP_MAX;
        clear_route();

        // cap, x, y, weight, first, pinned, cost, overweight
        probe_tab = '{
            '{CAP_MAX,      3,     -4,     5, 1'b0, 1'b1,     14, 1'b0}, // no first mark
            '{CAP_MAX,      3,     -4,     0, 1'b0, 1'b0,      0, 1'b0},
            '{CAP_MAX,  32767,  32767, 65535, 1'b1, 1'b1, 131068, 1'b0},
            '{CAP_MAX, -32768, -32768,     0, 1'b0, 1'b0,      0, 1'b0},
            '{CAP_MAX, -32768,  32767, 65535, 1'b0, 1'b0,      0, 1'b0},
            '{CAP_MAX, -32768,  32767, 65535, 1'b1, 1'b1, 131070, 1'b0},
            '{CAP_MAX,  32767, -32768,     1, 1'b0, 1'b0,      0, 1'b0},
            '{16'd0,        1,      1,     1, 1'b1, 1'b1,      0, 1'b1}, // overweight
            '{16'd0,        1,      1,     0, 1'b0, 1'b0,      0, 1'b0},
            '{16'd0,        0,      0,     0, 1'b1, 1'b1,      0, 1'b0},
            '{16'd0,       -5,      7,     0, 1'b0, 1'b0,      0, 1'b0},
            '{16'd100,     10,      0,    60, 1'b1, 1'b1,     20, 1'b0},
            '{16'd100,     10,     10,    50, 1'b0, 1'b0,      0, 1'b0},
            '{16'd100,      0,     10,   101, 1'b0, 1'b1,      0, 1'b1},
            '{16'd100,      0,     10,   100, 1'b0, 1'b0,      0, 1'b0},
            '{16'd100,      5,      5,     0, 1'b0, 1'b0,      0, 1'b0},
            '{16'd100,     20,     -3,     0, 1'b0, 1'b0,      0, 1'b0},
            '{16'd100,      1,      2,     0, 1'b0, 1'b0,      0, 1'b0},
            '{CAP_MAX,      1,      0,     0, 1'b1, 1'b1,      2, 1'b0},
            '{CAP_MAX,      2,      0,     0, 1'b0, 1'b0,      0, 1'b0},
            '{CAP_MAX,      2,      0,     0, 1'b0, 1'b0,      0, 1'b0}, // tie evicts
            '{CAP_MAX,     -2,      0,     0, 1'b0, 1'b0,      0, 1'b0}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probe_tab[i])
        begin
            if (probe_tab[i].cap != cap_now)
                set_capacity(probe_tab[i].cap);
            push_point(probe_tab[i].x, probe_tab[i].y, probe_tab[i].w, probe_tab[i].first,
                       probe_tab[i].pinned, probe_tab[i].cost, probe_tab[i].ovw);
        end

        run_phase(CAP_MAX, 20, 1'b1);
        run_phase(16'd0, 10, 1'b0);
        run_phase(16'($urandom), 20, 1'b1);
        run_phase(16'd300, 20, 1'b1);
        run_phase(16'd1, 10, 1'b1);

        // one long outward case: every split stays, so the deque overflows
        set_capacity(CAP_MAX);
        fx = $urandom_range(1, 3);
        fy = $urandom_range(0, 3);
        for (int k = 0; k < FILL_LEN; k++)
        begin
            push_point(16'(fx), 16'(fy), 16'($urandom_range(0, 63)), k == 0, 1'b0, '0, 1'b0);
            fx = fx + int'($urandom_range(0, 3));
            fy = fy + int'($urandom_range(1, 3));
        end
        // heavy point expires nearly every older entry
        push_point(16'(fx), 16'(fy), CAP_MAX, 1'b0, 1'b0, '0, 1'b0);

        run_phase(16'($urandom), 20, 1'b1);
        // closing stretch runs without idling
        run_phase(16'($urandom_range(1000, 20000)), 16, 1'b0);

        settle_all();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d points in %0d cases across %0d capacity writes, %0d results",
                 n_points, n_cases, n_cap_writes, n_results);
        $display("%0d overweight results, %0d deque overflow drops, deepest deque %0d",
                 n_ovw, n_drops, deepest);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- capacitated_pickup_route_cost.f -----
hw/rtl/crpc_pkg.sv
hw/rtl/crpc_mem.sv
hw/rtl/crpc_dist.sv
hw/rtl/capacitated_pickup_route_cost.sv
verif/testbench.sv
